@@ hdl/streaming_fir_filter_top_macros.svh @@
// Assertion macros of the filter's checker file.
`ifndef STREAMING_FIR_FILTER_TOP_MACROS_SVH
`define STREAMING_FIR_FILTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SFF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SFF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sff_pkg.sv @@
// Types, constants and helper functions of the streaming FIR filter.
package sff_pkg;

    // Fixed field widths of the item and configuration ports
    localparam int CIDX_W = 6;
    localparam int TAPS_W = 7;

    // Accumulator width and its limits
    localparam int ACC_W = 64;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Item commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_ROUND,
        ST_OUT
    } t_state;

    // Add two accumulator values, clamping at the signed limits
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

endpackage

@@ hdl/sff_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sff_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry each cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/streaming_fir_filter_top.sv @@
// Streaming direct-form FIR filter: one shared multiply-accumulate over RAM-held taps.
// Sample beat: per tap in use, one coefficient and one history RAM read feed the single
// multiplier; the products are summed, then rounded and clamped into the output register.
// Next beat is taken once the result is in the output register; samples do not overlap.
// Coefficient beats are taken while idle. After reset a clearing pass zeroes every entry
// of both RAMs; no beat is taken until it ends. Reset restores taps in use to MAX_TAPS.
module streaming_fir_filter_top
    import sff_pkg::*;
#(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input item channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_cmd,
    input  logic [CIDX_W-1:0]              i_coef_index,
    input  logic signed [COEF_WIDTH-1:0]   i_coef_value,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_filtered_sample,
    output logic                           o_saturated,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [TAPS_W-1:0]              i_cfg_data
);

    localparam int AW  = $clog2(MAX_TAPS);
    localparam int TCW = (TAPS_W > $clog2(MAX_TAPS + 1)) ? TAPS_W : $clog2(MAX_TAPS + 1);
    localparam int PW  = SAMPLE_WIDTH + COEF_WIDTH;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
    localparam logic signed [ACC_W-1:0] RND   = 64'sd1 <<< (COEF_WIDTH - 2);
    localparam logic signed [ACC_W-1:0] Y_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - 64'sd1;

    t_state r_state, n_state;

    logic [TCW-1:0]                r_taps;
    logic [AW-1:0]                 r_clr_cnt;
    logic [AW-1:0]                 r_wp;
    logic [AW-1:0]                 r_rd_addr;
    logic [AW-1:0]                 r_tap;
    logic [AW-1:0]                 r_last;
    logic                          r_rd_vld;
    logic                          r_prod_vld;
    logic signed [PW-1:0]          r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic                          r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_data;
    logic                          r_out_sat;

    logic                          w_clear;
    logic                          w_idle;
    logic                          w_issue;
    logic                          w_load;
    logic                          w_accept;
    logic                          w_coef_we;
    logic                          w_hist_we;
    logic [AW-1:0]                 w_coef_waddr;
    logic [AW-1:0]                 w_hist_waddr;
    logic [COEF_WIDTH-1:0]         w_coef_wdata;
    logic [SAMPLE_WIDTH-1:0]       w_hist_wdata;
    logic [COEF_WIDTH-1:0]         w_coef_rdata;
    logic [SAMPLE_WIDTH-1:0]       w_hist_rdata;
    logic signed [COEF_WIDTH-1:0]  w_coef_s;
    logic signed [SAMPLE_WIDTH-1:0] w_hist_s;
    logic [AW-1:0]                 w_last;
    logic                          w_idx_ok;
    logic signed [ACC_W-1:0]       w_y;

    // Next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid && (i_cmd == CMD_SAMPLE)) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_tap == r_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !r_prod_vld) n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State-decoded controls
    always_comb begin
        w_clear = 1'b0;
        w_idle  = 1'b0;
        w_issue = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            ST_CLEAR: w_clear = 1'b1;
            ST_IDLE:  w_idle  = 1'b1;
            ST_RUN:   w_issue = 1'b1;
            ST_OUT:   w_load  = !r_out_valid || !i_out_stall;
            default: begin
                w_idle = 1'b0;
            end
        endcase
    end

    assign o_in_stall = !w_idle;
    assign w_accept   = i_in_valid && w_idle;
    assign o_cfg_ready = 1'b1;

    // Clamp taps in use to 1..MAX_TAPS and keep the last tap index
    always_comb begin
        if (r_taps == '0) begin
            w_last = '0;
        end else if (r_taps > TCW'(MAX_TAPS)) begin
            w_last = LAST_ADDR;
        end else begin
            w_last = AW'(r_taps - TCW'(1));
        end
    end

    // Drop coefficient writes beyond the tap range
    assign w_idx_ok = 32'(i_coef_index) < MAX_TAPS;

    // RAM write ports: clearing pass, coefficient beats, new samples
    assign w_coef_we    = w_clear || (w_accept && (i_cmd == CMD_COEF) && w_idx_ok);
    assign w_coef_waddr = w_clear ? r_clr_cnt : AW'(i_coef_index);
    assign w_coef_wdata = w_clear ? '0 : i_coef_value;
    assign w_hist_we    = w_clear || (w_accept && (i_cmd == CMD_SAMPLE));
    assign w_hist_waddr = w_clear ? r_clr_cnt : r_wp;
    assign w_hist_wdata = w_clear ? '0 : i_sample_in;

    sff_ram #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_coef_waddr),
        .i_wdata (w_coef_wdata),
        .i_raddr (r_tap),
        .o_rdata (w_coef_rdata)
    );

    sff_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_hist_waddr),
        .i_wdata (w_hist_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (w_hist_rdata)
    );

    assign w_coef_s = w_coef_rdata;
    assign w_hist_s = w_hist_rdata;

    // Rescale the accumulator, already rounded half up, to sample format
    assign w_y = r_acc >>> (COEF_WIDTH - 1);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Taps-in-use register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= TCW'(MAX_TAPS);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_taps <= TCW'(i_cfg_data);
        end
    end

    // Sweep both RAMs after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (w_clear) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    // History write pointer and tap walk: newest sample first, walking back in time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rd_addr <= '0;
            r_tap     <= '0;
            r_last    <= '0;
        end else if (w_accept && (i_cmd == CMD_SAMPLE)) begin
            r_wp      <= (r_wp == LAST_ADDR) ? '0 : r_wp + AW'(1);
            r_rd_addr <= r_wp;
            r_tap     <= '0;
            r_last    <= w_last;
        end else if (w_issue) begin
            r_rd_addr <= (r_rd_addr == '0) ? LAST_ADDR : r_rd_addr - AW'(1);
            r_tap     <= r_tap + AW'(1);
        end
    end

    // Pipeline valid flags for read data and product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_rd_vld   <= w_issue;
            r_prod_vld <= r_rd_vld;
        end
    end

    // Multiply one tap
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_prod <= w_hist_s * w_coef_s;
        end
    end

    // Clear on an accepted beat, accumulate products, then add the rounding constant
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= sat_add(r_acc, ACC_W'(r_prod));
        end else if (r_state == ST_ROUND) begin
            r_acc <= sat_add(r_acc, RND);
        end
    end

    // Output register: load the clamped result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_y > Y_MAX) begin
                r_out_data <= SAMPLE_WIDTH'(Y_MAX);
                r_out_sat  <= 1'b1;
            end else if (w_y < Y_MIN) begin
                r_out_data <= SAMPLE_WIDTH'(Y_MIN);
                r_out_sat  <= 1'b1;
            end else begin
                r_out_data <= SAMPLE_WIDTH'(w_y);
                r_out_sat  <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_filtered_sample = r_out_data;
    assign o_saturated       = r_out_sat;

endmodule

@@ hdl/sff_checker.sv @@
// Port-level checker for the streaming FIR filter, bound to the top level.
`include "streaming_fir_filter_top_macros.svh"

module sff_checker
    import sff_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           i_cmd,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic signed [SAMPLE_WIDTH-1:0] o_filtered_sample,
    input logic                           o_saturated
);

    localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic w_in_beat;
    assign w_in_beat = i_in_valid && !o_in_stall;

    // A stalled result holds its value
    `SFF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_filtered_sample), "stalled result changed")

    // A coefficient beat never produces a result
    `SFF_ASSERT_NEXT(a_coef_silent, i_clk, i_rst_n, w_in_beat && (i_cmd == CMD_COEF), !$rose(o_out_valid), "coefficient beat made a result")

    // A sample beat keeps the block busy in the next cycle
    `SFF_ASSERT_NEXT(a_sample_busy, i_clk, i_rst_n, w_in_beat && (i_cmd == CMD_SAMPLE), o_in_stall, "input taken while filtering")

    // A clipped result sits at one of the range limits
    `SFF_ASSERT_NOW(a_sat_limit, i_clk, i_rst_n, o_out_valid && o_saturated, (o_filtered_sample == S_MAX) || (o_filtered_sample == S_MIN), "clip flag off the limits")

endmodule

bind streaming_fir_filter_top sff_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_sff_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .i_cmd             (i_cmd),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_filtered_sample (o_filtered_sample),
    .o_saturated       (o_saturated)
);

@@ tb/streaming_fir_filter_top_test.sv @@
// Self-checking testbench of the streaming FIR filter: random items, stalls and tap settings.
module streaming_fir_filter_top_test;
    import sff_pkg::*;

    localparam int TAPS_MAX    = 64;
    localparam int SW          = 16;
    localparam int CW          = 16;
    localparam int HOLD_CYCLES = 500;
    localparam int SETTLE      = 80;           // a full 64-tap pass plus pipeline slack
    localparam int SEG_ITEMS   = 95;
    localparam int SEGS        = 6;
    localparam int LIMIT       = 1_000_000;    // cycles before the run is abandoned

    typedef struct packed {
        logic signed [SW-1:0] value;
        logic                 clipped;
    } t_fir_out;

    // Filter predictor and store of expected outputs
    class fir_scoreboard;
        logic signed [CW-1:0] coef_taps [TAPS_MAX];
        logic signed [SW-1:0] past_x [TAPS_MAX-1];
        logic [TAPS_W-1:0]    taps_cfg;
        t_fir_out             expected_q [$];
        int                   mismatches;

        function new();
            foreach (coef_taps[k]) coef_taps[k] = '0;
            foreach (past_x[k]) past_x[k] = '0;
            taps_cfg   = TAPS_W'(TAPS_MAX);
            mismatches = 0;
        endfunction

        function void set_taps(logic [TAPS_W-1:0] v);
            taps_cfg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Apply one accepted input beat and queue the output it produces
        function void note_beat(logic cmd, logic [CIDX_W-1:0] idx,
                                logic signed [CW-1:0] cval, logic signed [SW-1:0] smp);
            int                   n;
            longint               acc;
            longint               y;
            logic signed [SW-1:0] tap_in;
            t_fir_out             res;
            if (cmd == CMD_COEF) begin
                coef_taps[idx] = cval;
                return;
            end
            n = taps_cfg;
            if (n < 1) n = 1;
            if (n > TAPS_MAX) n = TAPS_MAX;
            // 64 products of at most 2^30 stay far inside 64 bits
            acc = 0;
            for (int j = 0; j < n; j++) begin
                tap_in = (j == 0) ? smp : past_x[j-1];
                acc += longint'(tap_in) * longint'(coef_taps[j]);
            end
            // Round half up, then clip to the sample range
            acc += longint'(1) << (CW - 2);
            y = acc >>> (CW - 1);
            res.clipped = 1'b0;
            if (y > (longint'(1) << (SW - 1)) - 1) begin
                y = (longint'(1) << (SW - 1)) - 1;
                res.clipped = 1'b1;
            end else if (y < -(longint'(1) << (SW - 1))) begin
                y = -(longint'(1) << (SW - 1));
                res.clipped = 1'b1;
            end
            res.value = SW'(y);
            expected_q.push_back(res);
            // Shift the sample into the history
            for (int j = TAPS_MAX - 2; j > 0; j--) past_x[j] = past_x[j-1];
            past_x[0] = smp;
        endfunction

        // Compare one output beat with the oldest expected output
        function void check_beat(logic signed [SW-1:0] value, logic clipped);
            t_fir_out want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: output beat with nothing expected: value %0d sat %0b",
                             $time, value, clipped);
                return;
            end
            want = expected_q.pop_front();
            if (want.value !== value || want.clipped !== clipped) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: output mismatch: expected value %0d sat %0b, got %0d sat %0b",
                             $time, want.value, want.clipped, value, clipped);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_cmd = CMD_SAMPLE;
    logic [CIDX_W-1:0]    i_coef_index = '0;
    logic signed [CW-1:0] i_coef_value = '0;
    logic signed [SW-1:0] i_sample_in = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [SW-1:0] o_filtered_sample;
    logic                 o_saturated;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [TAPS_W-1:0]    i_cfg_data = '0;

    fir_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_ask = 0;
    int hold_seen = 0;
    int hold_left = 0;

    streaming_fir_filter_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_coef_index      (i_coef_index),
        .i_coef_value      (i_coef_value),
        .i_sample_in       (i_sample_in),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_filtered_sample (o_filtered_sample),
        .o_saturated       (o_saturated),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Abandon a hung run
    initial begin
        #(12 * LIMIT);
        $display("streaming_fir_filter_top verification failed");
        $finish;
    end

    // Check output beats and drive the output stall, with long hold-offs on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_beat(o_filtered_sample, o_saturated);
        if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offer one input beat after random idle cycles and hold it until taken
    task automatic push_beat(input logic cmd, input logic [CIDX_W-1:0] idx,
                             input logic signed [CW-1:0] cval,
                             input logic signed [SW-1:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_coef_index <= idx;
        i_coef_value <= cval;
        i_sample_in  <= smp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_beat(cmd, idx, cval, smp);
    endtask

    task automatic push_coef(input logic [CIDX_W-1:0] idx, input logic signed [CW-1:0] cval);
        push_beat(CMD_COEF, idx, cval, SW'($urandom));
    endtask

    task automatic push_sample(input logic signed [SW-1:0] smp);
        push_beat(CMD_SAMPLE, CIDX_W'($urandom), CW'($urandom), smp);
    endtask

    // Drain the filter, let it settle, then write the tap count
    task automatic write_taps(input logic [TAPS_W-1:0] v);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_taps(v);
    endtask

    // Q1.15 value: full range, scaled down, or a rail
    function automatic logic signed [15:0] rand_q15();
        logic signed [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(3))
            0: rand_q15 = v;
            1: rand_q15 = v >>> $urandom_range(14, 4);
            2: rand_q15 = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: rand_q15 = v >>> $urandom_range(8);
        endcase
    endfunction

    initial begin
        logic [TAPS_W-1:0] edge_taps [6];
        int                k;
        edge_taps = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd65, 7'd2};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: rails, rounding and both saturation directions at reset tap count, then at 0 and 127 taps
        send_idle_pct = 38;
        recv_idle_pct <= 69;
        push_sample(16'sh7FFF);
        push_coef(6'd0, 16'sh8000);
        push_sample(16'sh8000);
        push_coef(6'd1, 16'sh8000);
        push_sample(16'sh7FFF);
        push_sample(16'sh7FFF);
        push_coef(6'd63, 16'sh7FFF);
        push_coef(6'd0, 16'sh4000);
        push_coef(6'd1, 16'sh0000);
        push_sample(16'sh0001);
        push_sample(16'shFFFF);
        push_sample(16'sh0003);
        write_taps(7'd0);
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        write_taps(7'd127);
        push_coef(6'd63, 16'sh8000);
        push_sample(16'sh8000);
        push_sample(16'sh1234);

        // Random segments under three idling modes, a tap setting per segment
        for (int mode = 0; mode < 3; mode++) begin
            for (int seg = 0; seg < SEGS; seg++) begin
                k = mode * SEGS + seg;
                write_taps(k < 6 ? edge_taps[k] : TAPS_W'($urandom_range(127)));
                send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 69 : 0;
                recv_idle_pct <= (mode == 0) ? 69 : (mode == 1) ? 38 : 0;
                if (seg == 2) hold_ask <= hold_ask + 1;
                for (int n = 0; n < SEG_ITEMS; n++) begin
                    // Pause the sender until every output is back
                    if (seg == 3 && n == SEG_ITEMS / 2) begin
                        i_in_valid <= 1'b0;
                        @(posedge i_clk);
                        while (sb.pending() != 0) @(posedge i_clk);
                    end
                    if ($urandom_range(99) < 18)
                        push_coef(CIDX_W'($urandom), rand_q15());
                    else
                        push_sample(rand_q15());
                end
            end
        end

        // Drain and report
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("streaming_fir_filter_top verification clean");
        end else begin
            $display("streaming_fir_filter_top verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/sff_pkg.sv
hdl/sff_ram.sv
hdl/streaming_fir_filter_top.sv
hdl/sff_checker.sv
tb/streaming_fir_filter_top_test.sv
